>>> hdl/pass_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the plasma arc start supervisor.
// Used by pass_core and plasma_arc_start_supervisor; depends on nothing.
package pass_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_CORNER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_CUT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CAUSE_NONE         = 3'd0,
    CAUSE_AIR_START    = 3'd1,
    CAUSE_AIR_CUT      = 3'd2,
    CAUSE_TIMEOUT      = 3'd3,
    CAUSE_ARC_LOST     = 3'd4,
    CAUSE_ERROR_PIN    = 3'd5,
    CAUSE_REMOTE_ERROR = 3'd6,
    CAUSE_LINK_LOST    = 3'd7
  } cause_t;

  typedef enum logic [2:0] {
    REG_PIERCE_TIMEOUT = 3'd0,
    REG_ARC_DEBOUNCE   = 3'd1,
    REG_CORNER_PCT     = 3'd2,
    REG_CORNER_EN      = 3'd3,
    REG_ERROR_PIN_EN   = 3'd4,
    REG_BRIDGE_PRESENT = 3'd5,
    REG_UNUSED_6       = 3'd6,
    REG_UNUSED_7       = 3'd7
  } reg_index_t;

  localparam int SETPOINT_W = 10;
  localparam int PCT_W      = 7;
  localparam int OUT_W      = 24;
  localparam int PCT_SCALE  = 100;

  localparam int PIERCE_RESET   = 1000;
  localparam int DEBOUNCE_RESET = 50;
  localparam int PCT_RESET      = 90;

  typedef struct packed {
    logic ready_in;
    logic air_ok;
    logic error_in;
    logic remote_error;
    logic link_lost;
    logic abort_in;
  } pins_t;

  typedef struct packed {
    logic corner_enabled;
    logic error_pin_enabled;
    logic bridge_present;
  } cfg_flags_t;

  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint;
    cause_t                cause;
    logic                  alarm;
    mode_t                 mode;
    logic                  corner;
    logic                  start;
  } status_t;

endpackage

>>> hdl/pass_core.sv
`timescale 1ns / 1ps
// Supervisor state and the per-word state update for ticks, commands and
// corner checks. Depends on pass_pkg.
module pass_core #(
  parameter int TIMER_BITS = 16,
  parameter int RATE_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step_en,
  input  pass_pkg::kind_t                     kind,
  input  logic [pass_pkg::SETPOINT_W-1:0]     setpoint_volts,
  input  pass_pkg::pins_t                     pins,
  input  logic signed [RATE_BITS:0]           actual_rate,
  input  logic [RATE_BITS-1:0]                commanded_rate,
  input  logic [TIMER_BITS-1:0]               pierce_timeout_ms,
  input  logic [TIMER_BITS-1:0]               arc_loss_debounce_ms,
  input  logic [pass_pkg::PCT_W-1:0]          corner_threshold_pct,
  input  pass_pkg::cfg_flags_t                flags,
  output pass_pkg::status_t                   status_next
);
  import pass_pkg::*;

  localparam int PW = RATE_BITS + PCT_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  mode_t                 run_mode, run_mode_next;
  logic [TIMER_BITS-1:0] wait_elapsed, wait_elapsed_next;
  logic [TIMER_BITS:0]   low_ticks, low_ticks_next;
  logic                  alarm_latched, alarm_next;
  cause_t                cause_code, cause_next;
  logic                  start_line, start_next;
  logic                  corner_line, corner_next;
  logic [SETPOINT_W-1:0] held_setpoint, setpoint_next;

  logic                  fault_req;
  cause_t                fault_cause;
  logic [TIMER_BITS-1:0] wait_inc;
  logic [PW-1:0]         rate_lhs, rate_rhs;

  assign rate_lhs = PW'(actual_rate[RATE_BITS-1:0]) * PW'(PCT_SCALE);
  assign rate_rhs = PW'(corner_threshold_pct) * PW'(commanded_rate);
  assign wait_inc = (wait_elapsed < TIMER_MAX) ? wait_elapsed + 1'b1 : wait_elapsed;

  always_comb begin
    run_mode_next     = run_mode;
    wait_elapsed_next = wait_elapsed;
    low_ticks_next    = low_ticks;
    alarm_next        = alarm_latched;
    cause_next        = cause_code;
    start_next        = start_line;
    corner_next       = corner_line;
    setpoint_next     = held_setpoint;
    fault_req         = 1'b0;
    fault_cause       = CAUSE_NONE;

    case (kind)
      KIND_TICK: begin
        if (run_mode == MODE_WAIT) begin
          wait_elapsed_next = wait_inc;
          if (wait_inc >= pierce_timeout_ms) begin
            run_mode_next = MODE_OFF;
            fault_req     = 1'b1;
            fault_cause   = CAUSE_TIMEOUT;
          end else if (pins.abort_in) begin
            start_next    = 1'b0;
            run_mode_next = MODE_OFF;
          end else if (pins.ready_in) begin
            run_mode_next = MODE_CUT;
          end
        end else if (run_mode == MODE_CUT && !alarm_latched) begin
          if (flags.bridge_present && !pins.air_ok) begin
            fault_req   = 1'b1;
            fault_cause = CAUSE_AIR_CUT;
          end else begin
            if (!pins.ready_in) begin
              low_ticks_next = low_ticks + 1'b1;
              if (low_ticks != '0 && low_ticks >= {1'b0, arc_loss_debounce_ms}) begin
                low_ticks_next = '0;
                fault_req      = 1'b1;
                fault_cause    = CAUSE_ARC_LOST;
              end
            end else begin
              low_ticks_next = '0;
            end
            if (!fault_req) begin
              if (flags.error_pin_enabled && pins.error_in) begin
                fault_req   = 1'b1;
                fault_cause = CAUSE_ERROR_PIN;
              end else if (flags.bridge_present && pins.remote_error) begin
                fault_req   = 1'b1;
                fault_cause = CAUSE_REMOTE_ERROR;
              end else if (flags.bridge_present && pins.link_lost) begin
                fault_req   = 1'b1;
                fault_cause = CAUSE_LINK_LOST;
              end
            end
          end
        end
      end
      KIND_CORNER: begin
        if (flags.corner_enabled) begin
          if (actual_rate[RATE_BITS] || alarm_latched) begin
            corner_next = 1'b0;
          end else if (commanded_rate != '0) begin
            corner_next = rate_lhs < rate_rhs;
          end
        end
      end
      KIND_START: begin
        if (!pins.abort_in) begin
          if (flags.bridge_present) begin
            setpoint_next = setpoint_volts;
          end
          if (run_mode == MODE_CUT) begin
            corner_next = 1'b0;
            start_next  = 1'b0;
          end
          alarm_next        = 1'b0;
          cause_next        = CAUSE_NONE;
          low_ticks_next    = '0;
          wait_elapsed_next = '0;
          if (flags.bridge_present && !pins.air_ok) begin
            run_mode_next = MODE_OFF;
            fault_req     = 1'b1;
            fault_cause   = CAUSE_AIR_START;
          end else begin
            start_next = 1'b1;
            if (pierce_timeout_ms == '0) begin
              run_mode_next = MODE_OFF;
              fault_req     = 1'b1;
              fault_cause   = CAUSE_TIMEOUT;
            end else begin
              run_mode_next = pins.ready_in ? MODE_CUT : MODE_WAIT;
            end
          end
        end
      end
      KIND_STOP: begin
        if (!pins.abort_in) begin
          if (flags.bridge_present) begin
            setpoint_next = setpoint_volts;
          end
          corner_next       = 1'b0;
          start_next        = 1'b0;
          run_mode_next     = MODE_OFF;
          alarm_next        = 1'b0;
          cause_next        = CAUSE_NONE;
          low_ticks_next    = '0;
          wait_elapsed_next = '0;
        end
      end
      default: begin
      end
    endcase

    if (fault_req && !alarm_next) begin
      alarm_next  = 1'b1;
      cause_next  = fault_cause;
      start_next  = 1'b0;
      corner_next = 1'b0;
    end
  end

  assign status_next = '{setpoint: setpoint_next, cause: cause_next, alarm: alarm_next,
                         mode: run_mode_next, corner: corner_next, start: start_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= MODE_OFF;
      wait_elapsed  <= '0;
      low_ticks     <= '0;
      alarm_latched <= 1'b0;
      cause_code    <= CAUSE_NONE;
      start_line    <= 1'b0;
      corner_line   <= 1'b0;
      held_setpoint <= '0;
    end else if (step_en) begin
      run_mode      <= run_mode_next;
      wait_elapsed  <= wait_elapsed_next;
      low_ticks     <= low_ticks_next;
      alarm_latched <= alarm_next;
      cause_code    <= cause_next;
      start_line    <= start_next;
      corner_line   <= corner_next;
      held_setpoint <= setpoint_next;
    end
  end

endmodule

>>> hdl/plasma_arc_start_supervisor.sv
`timescale 1ns / 1ps
// Plasma arc start supervisor top level: configuration registers, input and
// result registers around pass_core. Depends on pass_pkg and pass_core.
//
// Input words arrive on the s_ stream: tuser carries the kind (millisecond
// tick with pin samples, start, stop or corner check), tdata the setpoint,
// the sampled pins and the two feed rates. Every input word yields exactly
// one result word on the m_ stream with the start and corner lines, the run
// mode, the alarm, the fault cause and the forwarded setpoint, all as they
// stand after that word.
// A word accepted into the input register has its result presented on m_tdata
// once it moves on into the result register. One word is taken every cycle
// while m_tready is high; each word is handled by one pass through the input
// register, the update logic and the result register.
// When the receiver holds m_tready low, the finished result stays put and one
// more word can still be taken into the input register; s_tready then drops
// until the result is taken.
// Reset clears the supervisor state to disabled with no alarm, empties both
// registers and loads the configuration registers with their defaults
// (1000 ms pierce timeout, 50 ms arc loss debounce, 90 percent corner
// threshold, corner and error pin off, remote link present).
// The APB port writes registers at byte addresses 4*i; reads return them.
module plasma_arc_start_supervisor #(
  parameter int TIMER_BITS = 16,
  parameter int RATE_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // setpoint_volts, ready_in, air_ok, error_in, remote_error, link_lost,
  // abort_in, actual_rate, commanded_rate; zero padded to whole bytes
  input  logic [((2*RATE_BITS+17+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // start_out, corner_out, mode, alarm, fault_cause, setpoint_out; zero padded
  output logic [pass_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pass_pkg::*;

  localparam int PIN_LSB  = SETPOINT_W;
  localparam int ACT_LSB  = PIN_LSB + 6;
  localparam int PROG_LSB = ACT_LSB + RATE_BITS + 1;

  logic [TIMER_BITS-1:0] pierce_timeout_ms;
  logic [TIMER_BITS-1:0] arc_loss_debounce_ms;
  logic [PCT_W-1:0]      corner_threshold_pct;
  cfg_flags_t            flags;

  logic                    in_valid;
  kind_t                   in_kind;
  logic [SETPOINT_W-1:0]   in_setpoint;
  pins_t                   in_pins;
  logic signed [RATE_BITS:0] in_actual;
  logic [RATE_BITS-1:0]    in_prog;

  logic       move;
  logic       cfg_write;
  reg_index_t cfg_index;
  status_t    status_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pierce_timeout_ms    <= TIMER_BITS'(PIERCE_RESET);
      arc_loss_debounce_ms <= TIMER_BITS'(DEBOUNCE_RESET);
      corner_threshold_pct <= PCT_W'(PCT_RESET);
      flags                <= '{corner_enabled: 1'b0, error_pin_enabled: 1'b0,
                                bridge_present: 1'b1};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIERCE_TIMEOUT: pierce_timeout_ms    <= pwdata[TIMER_BITS-1:0];
        REG_ARC_DEBOUNCE:   arc_loss_debounce_ms <= pwdata[TIMER_BITS-1:0];
        REG_CORNER_PCT:     corner_threshold_pct <= pwdata[PCT_W-1:0];
        REG_CORNER_EN:      flags.corner_enabled    <= pwdata[0];
        REG_ERROR_PIN_EN:   flags.error_pin_enabled <= pwdata[0];
        REG_BRIDGE_PRESENT: flags.bridge_present    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_PIERCE_TIMEOUT: prdata = 32'(pierce_timeout_ms);
      REG_ARC_DEBOUNCE:   prdata = 32'(arc_loss_debounce_ms);
      REG_CORNER_PCT:     prdata = 32'(corner_threshold_pct);
      REG_CORNER_EN:      prdata = 32'(flags.corner_enabled);
      REG_ERROR_PIN_EN:   prdata = 32'(flags.error_pin_enabled);
      REG_BRIDGE_PRESENT: prdata = 32'(flags.bridge_present);
      default:            prdata = '0;
    endcase
  end

  assign move     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind     <= kind_t'(s_tuser);
      in_setpoint <= s_tdata[SETPOINT_W-1:0];
      in_pins     <= '{ready_in: s_tdata[PIN_LSB], air_ok: s_tdata[PIN_LSB+1],
                       error_in: s_tdata[PIN_LSB+2], remote_error: s_tdata[PIN_LSB+3],
                       link_lost: s_tdata[PIN_LSB+4], abort_in: s_tdata[PIN_LSB+5]};
      in_actual   <= s_tdata[ACT_LSB +: RATE_BITS+1];
      in_prog     <= s_tdata[PROG_LSB +: RATE_BITS];
    end
    if (move) begin
      m_tdata <= {(OUT_W - SETPOINT_W - 8)'(0), status_next.setpoint, status_next.cause,
                  status_next.alarm, status_next.mode, status_next.corner,
                  status_next.start};
    end
  end

  pass_core #(
    .TIMER_BITS(TIMER_BITS),
    .RATE_BITS (RATE_BITS)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step_en             (move),
    .kind                (in_kind),
    .setpoint_volts      (in_setpoint),
    .pins                (in_pins),
    .actual_rate         (in_actual),
    .commanded_rate      (in_prog),
    .pierce_timeout_ms   (pierce_timeout_ms),
    .arc_loss_debounce_ms(arc_loss_debounce_ms),
    .corner_threshold_pct(corner_threshold_pct),
    .flags               (flags),
    .status_next         (status_next)
  );

endmodule
